// ===== hw/rtl/slot_allocator_free_stack_macros.svh =====
// ----------------------------------------------------------------------------
// Slot allocator assertion macros
// Concurrent assertion shorthands, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_FREE_STACK_MACROS_SVH
`define SLOT_ALLOCATOR_FREE_STACK_MACROS_SVH

// same-cycle implication
`define SFS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("slot allocator check failed");

// next-cycle implication
`define SFS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("slot allocator check failed");

`endif

// ===== hw/rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot allocator package
// Widths, operation codes and the command and status types shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int SLOT_W     = 12;
   localparam int CNT_W      = 13;
   localparam int POOL_SLOTS = 4096;

   localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SLOTS);

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_FLUSH   = 2'd2;

   // how a request is finished when its result is loaded
   typedef enum logic [2:0] {
      FIN_NONE,
      FIN_STACK,
      FIN_BUMP,
      FIN_RELEASE,
      FIN_EMPTY
   } fin_type;

   typedef struct packed {
      logic    load;
      logic    pop;
      logic    live_rd_slot;
      logic    live_rd_cand;
      fin_type fin;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic depth_zero;
      logic bump_full;
      logic cand_ok;
      logic rsp_free;
   } stat_type;

endpackage

// ===== hw/rtl/sfs_ifs.sv =====
// ----------------------------------------------------------------------------
// Slot allocator channels
// Valid/ready channels for requests, responses and the enable register.
// ----------------------------------------------------------------------------
interface sfs_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                op;
   logic [sfs_pkg::SLOT_W-1:0] slot;

   modport source (output valid, output op, output slot, input ready);
   modport sink   (input valid, input op, input slot, output ready);
endinterface

interface sfs_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      granted;
   logic [sfs_pkg::SLOT_W-1:0] slot_out;
   logic                      from_free_list;
   logic [sfs_pkg::CNT_W-1:0]  live_count;
   logic [sfs_pkg::CNT_W-1:0]  free_depth_out;

   modport source (output valid, output granted, output slot_out, output from_free_list,
                   output live_count, output free_depth_out, input ready);
   modport sink   (input valid, input granted, input slot_out, input from_free_list,
                   input live_count, input free_depth_out, output ready);
endinterface

interface sfs_csr_if;
   logic valid;
   logic ready;
   logic enable;

   modport source (output valid, output enable, input ready);
   modport sink   (input valid, input enable, output ready);
endinterface

// ===== hw/rtl/slot_allocator_free_stack.sv =====
// ----------------------------------------------------------------------------
// Slot allocator with free stack and bump pointer
// Hands out and takes back slots of a 4096-slot pool, one request at a time.
// ----------------------------------------------------------------------------
// Requests are handled one at a time; a finished response sits in an output
// register so the next request is taken while it waits. A release, a flush,
// an allocate while disabled and an allocate that finds the free stack empty
// pass through one work state before their response is loaded. An allocate
// served from the free stack pops an entry and then reads the live bit at the
// popped slot, and repeats this for every stale entry it pops: the free-stack
// memory read and the live-bit memory read are serial and set the rate. A
// stalled response holds the next finished request in its final state, so the
// input stalls once one response waits and another is done. Live bits at or
// above the bump mark are treated as dead, so no clearing pass runs after
// reset and requests are taken from the first cycle.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack (
   input  logic        clock,
   input  logic        reset,
   sfs_req_if.sink     req_chan,
   sfs_rsp_if.source   rsp_chan,
   sfs_csr_if.sink     csr_chan
);

   sfs_pkg::cmd_type  cmd;
   sfs_pkg::stat_type stat;
   logic              req_ready;

   assign req_chan.ready = req_ready;

   sfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sfs_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_op   (req_chan.op),
      .req_slot (req_chan.slot),
      .rsp      (rsp_chan),
      .csr      (csr_chan)
   );

endmodule

// ===== hw/rtl/sfs_datapath.sv =====
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Free stack and live-bit memories, depth, bump and live counters, enable
// register and the response register.
// ----------------------------------------------------------------------------
`include "slot_allocator_free_stack_macros.svh"

module sfs_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  sfs_pkg::cmd_type            cmd,
   output sfs_pkg::stat_type           stat,
   input  logic [1:0]                  req_op,
   input  logic [sfs_pkg::SLOT_W-1:0]  req_slot,
   sfs_rsp_if.source                   rsp,
   sfs_csr_if.sink                     csr
);

   logic [sfs_pkg::SLOT_W-1:0] stack_mem_ff [sfs_pkg::POOL_SLOTS];
   logic                       live_mem_ff  [sfs_pkg::POOL_SLOTS];

   logic [1:0]                 op_ff;
   logic [sfs_pkg::SLOT_W-1:0] slot_ff;
   logic [sfs_pkg::SLOT_W-1:0] cand_ff;
   logic                       live_rd_ff;

   logic [sfs_pkg::CNT_W-1:0]  depth_ff, depth_in;
   logic [sfs_pkg::CNT_W-1:0]  bump_ff, bump_in;
   logic [sfs_pkg::CNT_W-1:0]  total_ff, total_in;
   logic                       enable_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       granted_ff, granted_in;
   logic [sfs_pkg::SLOT_W-1:0] slot_out_ff, slot_out_in;
   logic                       ffl_ff, ffl_in;
   logic [sfs_pkg::CNT_W-1:0]  live_cnt_ff;
   logic [sfs_pkg::CNT_W-1:0]  depth_out_ff;

   logic [sfs_pkg::CNT_W-1:0]  depth_dec;
   logic                       stack_full;
   logic                       stack_we;
   logic                       cand_lt_bump;
   logic                       rel_live;
   logic                       rsp_free;
   logic                       live_re;
   logic                       live_we;
   logic                       live_wd;
   logic [sfs_pkg::SLOT_W-1:0] live_ra;
   logic [sfs_pkg::SLOT_W-1:0] live_wa;

   assign depth_dec    = depth_ff - 1'b1;
   assign stack_full   = (depth_ff == sfs_pkg::POOL_CNT);
   assign cand_lt_bump = ({1'b0, cand_ff} < bump_ff);
   // a slot at or above the bump mark was never handed out, so its live bit is ignored
   assign rel_live     = ({1'b0, slot_ff} < bump_ff) && live_rd_ff;
   assign rsp_free     = !rsp_valid_ff || rsp.ready;

   assign stat.enable     = enable_ff;
   assign stat.depth_zero = (depth_ff == '0);
   assign stat.bump_full  = (bump_ff == sfs_pkg::POOL_CNT);
   assign stat.cand_ok    = cand_lt_bump && !live_rd_ff;
   assign stat.rsp_free   = rsp_free;

   // free stack memory
   assign stack_we = (cmd.fin == sfs_pkg::FIN_RELEASE) && !stack_full;

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem_ff[depth_ff[sfs_pkg::SLOT_W-1:0]] <= slot_ff;
      end
      if (cmd.pop) begin
         cand_ff <= stack_mem_ff[depth_dec[sfs_pkg::SLOT_W-1:0]];
      end
   end

   // live-bit memory
   assign live_re = cmd.live_rd_slot || cmd.live_rd_cand;
   assign live_ra = cmd.live_rd_cand ? cand_ff : req_slot;

   always_comb begin
      live_we = 1'b1;
      live_wd = 1'b1;
      live_wa = cand_ff;
      unique case (cmd.fin)
         sfs_pkg::FIN_STACK: begin
            live_wa = cand_ff;
         end
         sfs_pkg::FIN_BUMP: begin
            live_wa = bump_ff[sfs_pkg::SLOT_W-1:0];
         end
         sfs_pkg::FIN_RELEASE: begin
            live_wa = slot_ff;
            live_wd = 1'b0;
         end
         sfs_pkg::FIN_EMPTY, sfs_pkg::FIN_NONE: begin
            live_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (live_we) begin
         live_mem_ff[live_wa] <= live_wd;
      end
      if (live_re) begin
         live_rd_ff <= live_mem_ff[live_ra];
      end
   end

   // counters and result
   always_comb begin
      depth_in    = depth_ff;
      bump_in     = bump_ff;
      total_in    = total_ff;
      granted_in  = 1'b0;
      slot_out_in = '0;
      ffl_in      = 1'b0;
      if (cmd.pop) begin
         depth_in = depth_dec;
      end
      unique case (cmd.fin)
         sfs_pkg::FIN_STACK: begin
            total_in    = total_ff + 1'b1;
            granted_in  = 1'b1;
            slot_out_in = cand_ff;
            ffl_in      = 1'b1;
         end
         sfs_pkg::FIN_BUMP: begin
            bump_in     = bump_ff + 1'b1;
            total_in    = total_ff + 1'b1;
            granted_in  = 1'b1;
            slot_out_in = bump_ff[sfs_pkg::SLOT_W-1:0];
         end
         sfs_pkg::FIN_RELEASE: begin
            if (rel_live && (total_ff != '0)) begin
               total_in = total_ff - 1'b1;
            end
            // drop the push when the stack is full
            if (!stack_full) begin
               depth_in   = depth_ff + 1'b1;
               granted_in = 1'b1;
            end
         end
         sfs_pkg::FIN_EMPTY: begin
            if (op_ff == sfs_pkg::OP_FLUSH) begin
               depth_in = '0;
            end
         end
         sfs_pkg::FIN_NONE: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.fin != sfs_pkg::FIN_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         bump_ff      <= '0;
         total_ff     <= '0;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         bump_ff      <= bump_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            enable_ff <= csr.enable;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         slot_ff <= req_slot;
      end
      if (cmd.fin != sfs_pkg::FIN_NONE) begin
         granted_ff   <= granted_in;
         slot_out_ff  <= slot_out_in;
         ffl_ff       <= ffl_in;
         live_cnt_ff  <= total_in;
         depth_out_ff <= depth_in;
      end
   end

   assign csr.ready          = 1'b1;
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.granted        = granted_ff;
   assign rsp.slot_out       = slot_out_ff;
   assign rsp.from_free_list = ffl_ff;
   assign rsp.live_count     = live_cnt_ff;
   assign rsp.free_depth_out = depth_out_ff;

   `SFS_ASSERT_NOW(a_stack_grant_valid, cmd.fin == sfs_pkg::FIN_STACK, stat.cand_ok)
   `SFS_ASSERT_NOW(a_bump_not_full, cmd.fin == sfs_pkg::FIN_BUMP, !stat.bump_full)
   `SFS_ASSERT_NOW(a_no_result_overwrite, cmd.fin != sfs_pkg::FIN_NONE, rsp_free)
   `SFS_ASSERT_NOW(a_pop_not_empty, cmd.pop, depth_ff != '0)
   `SFS_ASSERT_NOW(a_live_within_bump, 1'b1, total_ff <= bump_ff)

endmodule

// ===== hw/rtl/sfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slot allocator controller
// Sequences one request at a time: pop and check free-stack entries, fall
// back to the bump pointer, apply releases and flushes, load the response.
// ----------------------------------------------------------------------------
module sfs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_op,
   output logic              req_ready,
   input  sfs_pkg::stat_type stat,
   output sfs_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LADDR,
      ST_CHECK,
      ST_BUMP,
      ST_REL,
      ST_NOP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      cmd.load         = 1'b0;
      cmd.pop          = 1'b0;
      cmd.live_rd_slot = 1'b0;
      cmd.live_rd_cand = 1'b0;
      cmd.fin          = sfs_pkg::FIN_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               priority if (req_op == sfs_pkg::OP_ALLOC) begin
                  priority if (!stat.enable) begin
                     state_in = ST_NOP;
                  end else if (stat.depth_zero) begin
                     state_in = ST_BUMP;
                  end else begin
                     cmd.pop  = 1'b1;
                     state_in = ST_LADDR;
                  end
               end else if (req_op == sfs_pkg::OP_RELEASE) begin
                  cmd.live_rd_slot = 1'b1;
                  state_in         = ST_REL;
               end else begin
                  state_in = ST_NOP;
               end
            end
         end
         ST_LADDR: begin
            cmd.live_rd_cand = 1'b1;
            state_in         = ST_CHECK;
         end
         ST_CHECK: begin
            // hold a valid candidate until the response register frees up
            priority if (stat.cand_ok) begin
               if (stat.rsp_free) begin
                  cmd.fin  = sfs_pkg::FIN_STACK;
                  state_in = ST_IDLE;
               end
            end else if (stat.depth_zero) begin
               state_in = ST_BUMP;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_LADDR;
            end
         end
         ST_BUMP: begin
            if (stat.rsp_free) begin
               cmd.fin  = stat.bump_full ? sfs_pkg::FIN_EMPTY : sfs_pkg::FIN_BUMP;
               state_in = ST_IDLE;
            end
         end
         ST_REL: begin
            if (stat.rsp_free) begin
               cmd.fin  = sfs_pkg::FIN_RELEASE;
               state_in = ST_IDLE;
            end
         end
         ST_NOP: begin
            if (stat.rsp_free) begin
               cmd.fin  = sfs_pkg::FIN_EMPTY;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== test/slot_allocator_free_stack_checker.sv =====
// ----------------------------------------------------------------------------
// Slot allocator response checker
// Watches the request, response and enable channels, keeps its own copy of
// the free stack, bump mark and live bits, and compares each response with
// the outcome predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack_checker (
   input  logic clock,
   input  logic reset,
   sfs_req_if   req_chan,
   sfs_rsp_if   rsp_chan,
   sfs_csr_if   csr_chan,
   output int   mismatch_count,
   output int   outcome_backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;
   localparam int SLOT_W       = sfs_pkg::SLOT_W;
   localparam int CNT_W        = sfs_pkg::CNT_W;
   localparam int POOL_SLOTS   = sfs_pkg::POOL_SLOTS;

   typedef struct packed {
      logic              granted;
      logic [SLOT_W-1:0] slot_out;
      logic              from_free_list;
      logic [CNT_W-1:0]  live_count;
      logic [CNT_W-1:0]  free_depth_out;
   } outcome_type;

   logic [SLOT_W-1:0] free_slots [POOL_SLOTS];
   bit                slot_live  [POOL_SLOTS];
   int                free_top;
   int                bump_mark;
   int                live_slots;
   bit                alloc_enable;
   outcome_type       pending_outcomes [$];

   // Apply one request to the shadow state and return what the block must answer.
   function automatic outcome_type serve_request(logic [1:0] op, logic [SLOT_W-1:0] slot);
      outcome_type       res;
      logic [SLOT_W-1:0] cand;
      bit                found;
      res   = '0;
      found = 1'b0;
      if (op == sfs_pkg::OP_ALLOC && alloc_enable) begin
         // pop and drop stale entries until a dead slot below the bump mark turns up
         while (free_top > 0 && !found) begin
            free_top--;
            cand = free_slots[free_top];
            if (int'(cand) < bump_mark && int'(cand) < POOL_SLOTS && !slot_live[cand]) begin
               found              = 1'b1;
               res.slot_out       = cand;
               res.from_free_list = 1'b1;
            end
         end
         if (!found && bump_mark < POOL_SLOTS) begin
            found        = 1'b1;
            res.slot_out = SLOT_W'(bump_mark);
            bump_mark++;
         end
         if (found) begin
            res.granted             = 1'b1;
            slot_live[res.slot_out] = 1'b1;
            live_slots++;
         end
      end else if (op == sfs_pkg::OP_RELEASE && int'(slot) < POOL_SLOTS) begin
         if (slot_live[slot]) begin
            slot_live[slot] = 1'b0;
            if (live_slots > 0) live_slots--;
         end
         // a full stack drops the push but the slot stays dead
         if (free_top < POOL_SLOTS) begin
            free_slots[free_top] = slot;
            free_top++;
            res.granted = 1'b1;
         end
      end else if (op == sfs_pkg::OP_FLUSH) begin
         free_top = 0;
      end
      res.live_count     = CNT_W'(live_slots);
      res.free_depth_out = CNT_W'(free_top);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      outcome_type got;
      if (reset) begin
         free_top     = 0;
         bump_mark    = 0;
         live_slots   = 0;
         alloc_enable = 1'b0;
         foreach (slot_live[i]) slot_live[i] = 1'b0;
         pending_outcomes.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) alloc_enable = csr_chan.enable;
         if (req_chan.valid && req_chan.ready)
            pending_outcomes.insert(pending_outcomes.size(),
                                    serve_request(req_chan.op, req_chan.slot));
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.granted, rsp_chan.slot_out, rsp_chan.from_free_list,
                   rsp_chan.live_count, rsp_chan.free_depth_out};
            if (pending_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%t: response with no request outstanding: granted=%0b slot=%0d",
                           $realtime, got.granted, got.slot_out);
            end else begin
               want = pending_outcomes.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%t: response mismatch", $realtime);
                     $display("   expected granted=%0b slot=%0d from_free=%0b live=%0d depth=%0d",
                              want.granted, want.slot_out, want.from_free_list,
                              want.live_count, want.free_depth_out);
                     $display("   actual   granted=%0b slot=%0d from_free=%0b live=%0d depth=%0d",
                              got.granted, got.slot_out, got.from_free_list,
                              got.live_count, got.free_depth_out);
                  end
               end
            end
         end
      end
      outcome_backlog = pending_outcomes.size();
   end

endmodule

// ===== test/slot_allocator_free_stack_test.sv =====
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Drives allocate, release and flush requests with random gaps and response
// stalls, holds the response side off once to fill the block, and toggles
// the enable register between phases while a checker compares results.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         SLOT_W        = sfs_pkg::SLOT_W;
   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         LIMIT_CYCLES  = 1_000_000;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         RANDOM_BLOCKS = 8;
   localparam int         BLOCK_ITEMS   = 85;
   localparam int         SLOT_WINDOW   = 95;
   localparam int         SETTLE_CYCLES = 10;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   outcome_backlog;
   bit   calm;
   bit   rsp_hold_pending;

   sfs_req_if req_chan ();
   sfs_rsp_if rsp_chan ();
   sfs_csr_if csr_chan ();

   slot_allocator_free_stack dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   slot_allocator_free_stack_checker sfs_check (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_chan        (csr_chan),
      .mismatch_count  (mismatch_count),
      .outcome_backlog (outcome_backlog)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one request and hold it until the transfer; leaves valid high.
   task automatic send_req(logic [1:0] op, logic [SLOT_W-1:0] slot);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.slot  <= slot;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering and wait until every outstanding response has come back.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (outcome_backlog != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_enable(bit value);
      drain();
      csr_chan.valid  <= 1'b1;
      csr_chan.enable <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Mostly allocates and releases near the bump mark, now and then noise.
   task automatic random_request();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 46)
         send_req(sfs_pkg::OP_ALLOC, SLOT_W'($urandom));
      else if (roll < 92)
         send_req(sfs_pkg::OP_RELEASE,
                  ($urandom_range(0, 9) < 8) ? SLOT_W'($urandom_range(0, SLOT_WINDOW))
                                             : SLOT_W'($urandom));
      else if (roll < 97)
         send_req(sfs_pkg::OP_FLUSH, SLOT_W'($urandom));
      else
         send_req(OP_UNUSED, SLOT_W'($urandom));
   endtask

   // Response side: random stalls, plus one long hold when asked.
   initial begin
      int hold_count;
      bit hold_done;
      rsp_chan.ready = 1'b0;
      hold_done      = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_pending && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(negedge clock);
               hold_count++;
            end
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.op      = sfs_pkg::OP_ALLOC;
      req_chan.slot    = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.enable  = 1'b0;
      calm             = 1'b0;
      rsp_hold_pending = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // disabled after reset: allocates fail, releases still push
      send_req(sfs_pkg::OP_ALLOC, '1);
      send_req(sfs_pkg::OP_RELEASE, '1);
      send_req(sfs_pkg::OP_RELEASE, '0);
      send_req(OP_UNUSED, '0);
      send_req(sfs_pkg::OP_FLUSH, '1);
      send_req(sfs_pkg::OP_ALLOC, '0);

      write_enable(1'b1);
      send_req(sfs_pkg::OP_ALLOC, '0);
      send_req(sfs_pkg::OP_ALLOC, '0);
      send_req(sfs_pkg::OP_ALLOC, '1);
      send_req(sfs_pkg::OP_RELEASE, 12'd1);
      send_req(sfs_pkg::OP_RELEASE, 12'd2);
      send_req(sfs_pkg::OP_RELEASE, '1);          // above the bump mark: stale once popped
      send_req(sfs_pkg::OP_ALLOC, '0);
      send_req(sfs_pkg::OP_RELEASE, 12'd0);
      send_req(sfs_pkg::OP_RELEASE, 12'd0);       // not live any more, pushed again
      send_req(sfs_pkg::OP_ALLOC, '0);
      send_req(sfs_pkg::OP_ALLOC, '0);            // skips the copy that is live again
      send_req(sfs_pkg::OP_ALLOC, '0);
      send_req(sfs_pkg::OP_RELEASE, 12'd2);
      send_req(sfs_pkg::OP_FLUSH, '0);
      send_req(sfs_pkg::OP_ALLOC, '0);
      send_req(OP_UNUSED, '1);

      write_enable(1'b0);
      send_req(sfs_pkg::OP_ALLOC, '0);
      send_req(sfs_pkg::OP_RELEASE, 12'd3);
      send_req(sfs_pkg::OP_ALLOC, '0);

      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         write_enable((b == 5) ? 1'b0 : ((b == 0) ? 1'b1 : ($urandom_range(0, 4) != 0)));
         for (int i = 0; i < BLOCK_ITEMS; i++) begin
            if (b == 2 && i == 10) rsp_hold_pending = 1'b1;
            if (b == 4 && i == 50) drain();
            random_request();
         end
      end

      write_enable(1'b1);
      drain();
      calm = 1'b1;
      repeat (BLOCK_ITEMS) random_request();

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outcome_backlog == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
